@@ rtl/lfbr_pkg.sv @@
`timescale 1ns / 1ps
package lfbr_pkg;

  // Whole-byte count carried with a read; wide enough for the largest read limit.
  localparam int CNT_W = 6;

  localparam logic [2:0] ACT_LOAD  = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_SKIP  = 3'd2;
  localparam logic [2:0] ACT_SEEK  = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [12:0] byte_index;
    logic [7:0]  load_data;
    logic [12:0] byte_count;
    logic [2:0]  bit_count;
  } cmd_t;

  typedef struct packed {
    logic        short_error;
    logic [12:0] position_byte;
    logic [2:0]  position_bit;
    logic [12:0] bytes_left;
    logic [2:0]  bits_buffered;
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_of_run;
    logic        short_error;
    logic [12:0] position_byte;
    logic [2:0]  position_bit;
    logic [12:0] bytes_left;
    logic [2:0]  bits_buffered;
  } res_t;

  typedef enum logic [1:0] {
    JOB_LOAD,
    JOB_READ,
    JOB_STATUS
  } job_kind_t;

  typedef enum logic [1:0] {
    HELD_KEEP,
    HELD_ZERO,
    HELD_REFILL
  } held_op_t;

  typedef struct packed {
    job_kind_t        kind;
    held_op_t         held_op;
    logic [12:0]      addr;
    logic [7:0]       load_data;
    logic [2:0]       hcnt;
    logic [CNT_W-1:0] nbytes;
    logic [2:0]       nbits;
    logic [3:0]       shift;
    status_t          status;
  } job_t;

endpackage

@@ rtl/lfbr_stream_if.sv @@
`timescale 1ns / 1ps
interface lfbr_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/lfbr_front.sv @@
`timescale 1ns / 1ps
module lfbr_front #(
  parameter int BUFFER_BYTES   = 4096,
  parameter int MAX_READ_BYTES = 32
) (
  input  logic          clk,
  input  logic          rst,
  lfbr_stream_if.sink   cmd,
  lfbr_stream_if.sink   cfg,
  lfbr_stream_if.source job
);
  import lfbr_pkg::*;

  logic [12:0] len_use;
  logic [12:0] next_byte;
  logic [2:0]  hcnt;
  logic        err;

  cmd_t        c;
  logic        carry;
  logic [12:0] left;
  logic [13:0] need;
  logic        fits;
  logic [12:0] mv_next;
  logic [2:0]  mv_h;
  logic [12:0] mv_left;
  logic [12:0] seek_left;
  logic [12:0] next_byte_next;
  logic [2:0]  hcnt_next;
  logic        err_next;
  logic [12:0] left_next;
  job_t        j;
  logic        accept;

  assign c      = cmd.data;
  assign accept = cmd.valid && job.ready;

  // The cursor is owned here: every command is checked and its final position
  // worked out before the job is queued, so the back end only moves data.
  always_comb begin
    carry     = c.bit_count > hcnt;
    left      = (next_byte < len_use) ? len_use - next_byte : '0;
    need      = {1'b0, c.byte_count} + {13'd0, carry};
    fits      = {1'b0, left} >= need;
    mv_next   = next_byte + c.byte_count + {12'd0, carry};
    mv_h      = hcnt - c.bit_count;
    mv_left   = left - need[12:0];
    seek_left = len_use - c.byte_index;

    next_byte_next = next_byte;
    hcnt_next      = hcnt;
    err_next       = err;
    left_next      = left;
    j              = '0;
    j.kind         = JOB_STATUS;
    j.held_op      = HELD_KEEP;

    unique case (c.action)
      ACT_LOAD: begin
        if (32'(c.byte_index) < BUFFER_BYTES) begin
          j.kind      = JOB_LOAD;
          j.addr      = c.byte_index;
          j.load_data = c.load_data;
        end
      end
      ACT_READ: begin
        if (32'(c.byte_count) > MAX_READ_BYTES || !fits) begin
          err_next = 1'b1;
        end else if (c.byte_count != '0 || c.bit_count != '0) begin
          j.kind         = JOB_READ;
          j.addr         = next_byte;
          j.hcnt         = hcnt;
          j.nbytes       = c.byte_count[CNT_W-1:0];
          j.nbits        = c.bit_count;
          next_byte_next = mv_next;
          hcnt_next      = mv_h;
          left_next      = mv_left;
        end
      end
      ACT_SKIP: begin
        if (!fits) begin
          err_next = 1'b1;
        end else begin
          next_byte_next = mv_next;
          hcnt_next      = mv_h;
          left_next      = mv_left;
          // The held bits always come from the byte just before the new cursor.
          if (hcnt != '0 || c.bit_count != '0) begin
            j.held_op = HELD_REFILL;
            j.addr    = mv_next - 13'd1;
            j.shift   = carry ? {1'b0, c.bit_count - hcnt}
                              : 4'd8 - {1'b0, hcnt} + {1'b0, c.bit_count};
          end
        end
      end
      ACT_SEEK: begin
        if (c.byte_index > len_use) begin
          err_next = 1'b1;
        end else begin
          next_byte_next = c.byte_index;
          hcnt_next      = '0;
          left_next      = seek_left;
          j.held_op      = HELD_ZERO;
          if (c.bit_count != '0) begin
            // A bit offset at the very end moves the cursor but still flags.
            if (seek_left == '0) begin
              err_next = 1'b1;
            end else begin
              next_byte_next = c.byte_index + 13'd1;
              hcnt_next      = 3'd0 - c.bit_count;
              left_next      = seek_left - 13'd1;
              j.held_op      = HELD_REFILL;
              j.addr         = c.byte_index;
              j.shift        = {1'b0, c.bit_count};
            end
          end
        end
      end
      ACT_CLEAR: begin
        err_next = 1'b0;
      end
      default: begin
      end
    endcase

    j.status.short_error   = err_next;
    j.status.position_byte = (hcnt_next != '0) ? next_byte_next - 13'd1 : next_byte_next;
    j.status.position_bit  = 3'd0 - hcnt_next;
    j.status.bytes_left    = left_next;
    j.status.bits_buffered = hcnt_next;
  end

  assign job.valid = cmd.valid;
  assign job.data  = j;
  assign cmd.ready = job.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_use   <= '0;
      next_byte <= '0;
      hcnt      <= '0;
      err       <= 1'b0;
    end else begin
      if (cfg.valid) begin
        len_use <= (32'(cfg.data) < BUFFER_BYTES) ? cfg.data : 13'(BUFFER_BYTES);
      end
      if (accept) begin
        next_byte <= next_byte_next;
        hcnt      <= hcnt_next;
        err       <= err_next;
      end
    end
  end

endmodule

@@ rtl/lfbr_queue.sv @@
`timescale 1ns / 1ps
module lfbr_queue (
  input  logic          clk,
  input  logic          rst,
  lfbr_stream_if.sink   din,
  lfbr_stream_if.source dout
);
  import lfbr_pkg::*;

  job_t        slots [2];
  logic        wp;
  logic        rp;
  logic [1:0]  cnt;
  logic        push;
  logic        pop;

  assign din.ready  = cnt != 2'd2;
  assign dout.valid = cnt != 2'd0;
  assign dout.data  = slots[rp];
  assign push       = din.valid && din.ready;
  assign pop        = dout.valid && dout.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= din.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

@@ rtl/lfbr_back.sv @@
`timescale 1ns / 1ps
module lfbr_back #(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic          clk,
  input  logic          rst,
  lfbr_stream_if.sink   job,
  lfbr_stream_if.source res
);
  import lfbr_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REFILL,
    ST_READ
  } state_t;

  logic [7:0]       mem [BUFFER_BYTES];
  logic [7:0]       rd;

  state_t           state;
  job_t             cur;
  logic [7:0]       held;
  logic             rd_valid;
  logic [CNT_W:0]   fetch_left;
  logic [12:0]      fetch_addr;
  logic [CNT_W-1:0] whole_left;

  logic             out_free;
  logic             take;
  logic             jcarry;
  logic [CNT_W:0]   jcount;
  logic             carry;
  logic             is_whole;
  logic             need_rd;
  logic             step;
  logic             consume;
  logic [7:0]       rd_sh;
  logic [7:0]       mask;
  logic [7:0]       data;
  logic [7:0]       held_next;
  logic             last;
  logic             mem_we;
  logic             mem_re;
  logic [12:0]      raddr;
  logic             res_emit;

  function automatic res_t mk_res(logic [7:0] d, logic l, status_t s);
    res_t r;
    r.data_byte     = d;
    r.last_of_run   = l;
    r.short_error   = s.short_error;
    r.position_byte = s.position_byte;
    r.position_bit  = s.position_bit;
    r.bytes_left    = s.bytes_left;
    r.bits_buffered = s.bits_buffered;
    return r;
  endfunction

  assign out_free  = !res.valid || res.ready;
  assign job.ready = (state == ST_IDLE) && out_free;
  assign take      = job.valid && job.ready;

  always_comb begin
    jcarry   = job.data.nbits > job.data.hcnt;
    jcount   = {1'b0, job.data.nbytes} + {{CNT_W{1'b0}}, jcarry};
    carry    = cur.nbits > cur.hcnt;
    is_whole = whole_left != '0;
    need_rd  = is_whole || carry;
    step     = (state == ST_READ) && out_free && (!need_rd || rd_valid);
    consume  = step && need_rd;
    rd_sh    = rd << cur.hcnt;
    mask     = (8'd1 << cur.nbits) - 8'd1;
    last     = !is_whole || (whole_left == CNT_W'(1) && cur.nbits == '0);

    // A status word leaves straight from the idle state unless it waits on a refill.
    res_emit = state == ST_REFILL || step ||
               (take && job.data.kind != JOB_READ &&
                !(job.data.kind == JOB_STATUS && job.data.held_op == HELD_REFILL));

    // Whole bytes splice the held bits under the fresh byte; the trailing
    // partial byte takes from the held bits and, if they run short, one more byte.
    if (is_whole) begin
      data      = held | rd_sh;
      held_next = rd >> (4'd8 - {1'b0, cur.hcnt});
    end else if (carry) begin
      data      = (held | rd_sh) & mask;
      held_next = rd >> (cur.nbits - cur.hcnt);
    end else begin
      data      = held & mask;
      held_next = held >> cur.nbits;
    end

    mem_we = take && job.data.kind == JOB_LOAD;
    mem_re = 1'b0;
    raddr  = job.data.addr;
    if (take && job.data.kind == JOB_STATUS && job.data.held_op == HELD_REFILL) begin
      mem_re = 1'b1;
    end else if (take && job.data.kind == JOB_READ && jcount != '0) begin
      mem_re = 1'b1;
    end else if (state == ST_READ && fetch_left != '0 && (!rd_valid || consume)) begin
      mem_re = 1'b1;
      raddr  = fetch_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(job.data.addr)] <= job.data.load_data;
    end
    if (mem_re) begin
      rd <= mem[AW'(raddr)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      res.valid  <= 1'b0;
      held       <= '0;
      rd_valid   <= 1'b0;
      fetch_left <= '0;
      whole_left <= '0;
    end else begin
      if (res_emit) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            cur <= job.data;
            unique case (job.data.kind)
              JOB_READ: begin
                whole_left <= job.data.nbytes;
                fetch_addr <= job.data.addr + 13'd1;
                rd_valid   <= jcount != '0;
                fetch_left <= (jcount != '0) ? jcount - 1'b1 : '0;
                state      <= ST_READ;
              end
              JOB_STATUS: begin
                if (job.data.held_op == HELD_REFILL) begin
                  state <= ST_REFILL;
                end else begin
                  if (job.data.held_op == HELD_ZERO) begin
                    held <= '0;
                  end
                  res.data <= mk_res(8'd0, 1'b1, job.data.status);
                end
              end
              default: begin
                res.data <= mk_res(8'd0, 1'b1, job.data.status);
              end
            endcase
          end
        end
        ST_REFILL: begin
          held     <= rd >> cur.shift;
          res.data <= mk_res(8'd0, 1'b1, cur.status);
          state    <= ST_IDLE;
        end
        ST_READ: begin
          if (step) begin
            res.data <= mk_res(data, last, cur.status);
            held     <= held_next;
            if (is_whole) begin
              whole_left <= whole_left - 1'b1;
            end
            if (last) begin
              state <= ST_IDLE;
            end
          end
          if (mem_re) begin
            fetch_left <= fetch_left - 1'b1;
            fetch_addr <= fetch_addr + 13'd1;
            rd_valid   <= 1'b1;
          end else if (consume) begin
            rd_valid <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/lsb_first_bit_reader.sv @@
`timescale 1ns / 1ps
// LSB-first bit reader over a byte buffer of BUFFER_BYTES entries. The front end
// takes one command word per cycle while its two-entry job queue has room, checks
// it against the buffer length and moves the cursor; the back end owns the byte
// memory and the held bits. A load, clear, failed or empty request, or a seek
// without bit offset, leaves the back end in the cycle after it is taken; a skip
// that starts or ends with bits held, or a seek with a bit offset short of the end,
// first passes through the refill state to wait on the memory's registered read
// port. A read of N whole bytes streams N result words, plus one for a trailing
// partial byte, one per cycle from that port unless the downstream side stalls. The
// user must write the buffer length register only while idle; it is not enforced.
module lsb_first_bit_reader #(
  parameter int BUFFER_BYTES   = 4096,
  parameter int MAX_READ_BYTES = 32
) (
  input  logic          clk,
  input  logic          rst,
  lfbr_stream_if.sink   cmd,
  lfbr_stream_if.sink   cfg,
  lfbr_stream_if.source res
);
  import lfbr_pkg::*;

  lfbr_stream_if #(.T(job_t)) fq ();
  lfbr_stream_if #(.T(job_t)) qb ();

  lfbr_front #(
    .BUFFER_BYTES   (BUFFER_BYTES),
    .MAX_READ_BYTES (MAX_READ_BYTES)
  ) u_front (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .cfg (cfg),
    .job (fq)
  );

  lfbr_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .din  (fq),
    .dout (qb)
  );

  lfbr_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk (clk),
    .rst (rst),
    .job (qb),
    .res (res)
  );

endmodule
